@@ hdl/cdps_pkg.sv @@
package cdps_pkg;

  // quotient bits of the gain divider
  localparam int QUOT_W = 16;

  // requests the datapath can hold: three front stages, three divider stages, final and output
  localparam int PIPE_DEPTH = 8;

  // bias register after reset
  localparam logic [13:0] BIAS_RESET = 14'd650;

  // switch codes
  localparam logic [1:0] SW_UP_ON  = 2'd0;
  localparam logic [1:0] SW_UP_BYP = 2'd1;
  localparam logic [1:0] SW_DN_ON  = 2'd2;
  localparam logic [1:0] SW_DN_BYP = 2'd3;

  // last switch value before any request was seen
  localparam logic [2:0] SW_NONE = 3'd7;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [1:0]         switch_mode;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
  } out_item_t;

endpackage

@@ hdl/cdps_ram.sv @@
module cdps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 701
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, two registered read ports, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

@@ hdl/crossfade_delay_pitch_shifter.sv @@
// Pipeline: an accepted request passes 3 front stages, 3 divider stages and 2 output stages
// on its way to out_valid; while the output stalls, the stages behind it and in_ready hold.
// Throughput: one request per cycle when not stalled; each takes one store write and two tap reads.
// Reset (rst_n low at a clock edge) empties the pipeline, returns taps, gain and switch tracking
// to their start values and the bias to 650; the store needs no clearing pass, since a
// fill mark makes entries not yet written read as zero.
module crossfade_delay_pitch_shifter #(
  parameter int DELAY_SPAN = 700
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cdps_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cdps_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [13:0]         cfg_data
);

  localparam int SPAN2 = 2 * DELAY_SPAN;
  localparam int DEPTH = DELAY_SPAN + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int HW    = $clog2(SPAN2 + 1);
  localparam int GW    = $clog2(DELAY_SPAN + 1);
  localparam int QW    = cdps_pkg::QUOT_W;
  localparam int EW    = GW + 17;
  localparam int MW    = GW + 16;

  // reciprocal of the span, exact floor for every magnitude below 2**MW
  localparam int            KSH   = MW + $clog2(DELAY_SPAN);
  localparam int            RW    = MW + 1;
  localparam int            PW    = MW + RW;
  localparam logic [63:0]   POW_K = 64'd1 << KSH;
  localparam logic [RW-1:0] RECIP = RW'((POW_K + 64'(DELAY_SPAN) - 64'd1) / 64'(DELAY_SPAN));

  localparam logic [AW-1:0] LAST_A  = AW'(DELAY_SPAN);
  localparam logic [AW:0]   DEPTH_X = (AW + 1)'(DEPTH);
  localparam logic [HW-1:0] SPAN_H  = HW'(DELAY_SPAN);
  localparam logic [HW-1:0] SPAN2_H = HW'(SPAN2);
  localparam logic [GW-1:0] SPAN_G  = GW'(DELAY_SPAN);
  localparam logic [MW-1:0] SPAN_M  = MW'(DELAY_SPAN);

  typedef struct packed {
    logic [GW-1:0]      g;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               shift;
    logic               fwd_a;
    logic               fwd_b;
    logic               vld_a;
    logic               vld_b;
  } front_t;

  typedef struct packed {
    logic [GW-1:0]      g;
    logic signed [16:0] diff;
    logic signed [17:0] base;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               shift;
  } mix_t;

  typedef struct packed {
    logic signed [EW-1:0] prod;
    logic signed [17:0]   base;
    logic signed [15:0]   left;
    logic signed [15:0]   right;
    logic                 shift;
  } prod_t;

  typedef struct packed {
    logic               neg;
    logic signed [17:0] base;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               shift;
  } side_t;

  typedef struct packed {
    logic signed [18:0] sum;
    logic               frac_pos;
    logic               frac_neg;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic               shift;
  } fin_t;

  // tap read index relative to the advanced write pointer
  function automatic logic [AW-1:0] rd_index(input logic [HW-1:0] halves,
                                             input logic [AW-1:0] wn);
    logic [AW-1:0] d;
    logic [AW:0]   t;
    d = AW'(halves >> 1);
    if (wn >= d) begin
      t = {1'b0, wn} - {1'b0, d};
    end else begin
      t = {1'b0, wn} + DEPTH_X - {1'b0, d};
    end
    return t[AW-1:0];
  endfunction

  // architectural state
  logic [AW-1:0] wr_idx_r;
  logic          full_r;
  logic [HW-1:0] halves_r;
  logic [GW-1:0] fade_r;
  logic          rising_r;
  logic          pitch_up_r;
  logic          shift_en_r;
  logic [2:0]    last_sw_r;
  logic [13:0]   bias_r;

  logic [AW-1:0] wr_idx_nxt;
  logic [HW-1:0] halves_base;
  logic [HW-1:0] halves_nxt;
  logic [HW-1:0] halves_b;
  logic [GW-1:0] fade_base;
  logic [GW-1:0] fade_nxt;
  logic          rising_nxt;
  logic          pitch_up_nxt;
  logic          shift_en_nxt;
  logic          sw_chg;
  logic [1:0]    sw;
  logic [AW-1:0] ra;
  logic [AW-1:0] rb;
  logic          in_acc;

  // pipeline
  logic               p1_v_r, p2_v_r, p3_v_r, pf_v_r, out_v_r;
  logic               p1_en, p2_en, p3_en, pf_en, out_en;
  front_t             p1_r;
  mix_t               p2_r;
  prod_t              p3_r;
  fin_t               pf_r;
  cdps_pkg::out_item_t out_r;
  logic [15:0]        rd_a;
  logic [15:0]        rd_b;
  logic signed [15:0] xa;
  logic signed [15:0] xb;
  logic signed [GW+17:0] prod_full;
  logic [EW-1:0]      mag;

  logic               dv0_v_r, dv1_v_r, dv2_v_r;
  logic               dv0_en, dv1_en, dv2_en;
  logic [MW-1:0]      dv0_mag_r;
  logic [MW-1:0]      dv1_mag_r;
  logic [QW-1:0]      dv1_q_r;
  logic [QW-1:0]      dv2_q_r;
  logic               dv2_nz_r;
  side_t              dv0_side_r, dv1_side_r, dv2_side_r;
  logic [PW-1:0]      dv_prod;
  logic [MW-1:0]      dv_back;

  logic [18:0]        q_ext;
  logic [18:0]        q_signed;
  logic signed [18:0] adj;
  logic signed [15:0] sat;

  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign sw        = in_data.switch_mode;

  // switch handling
  assign sw_chg       = ({1'b0, sw} != last_sw_r);
  assign pitch_up_nxt = sw_chg ? (sw == cdps_pkg::SW_UP_ON || sw == cdps_pkg::SW_UP_BYP)
                               : pitch_up_r;
  assign shift_en_nxt = sw_chg ? (sw == cdps_pkg::SW_UP_ON || sw == cdps_pkg::SW_DN_ON)
                               : shift_en_r;

  always_comb begin
    priority if (sw_chg && sw == cdps_pkg::SW_UP_ON) begin
      halves_base = SPAN2_H;
      fade_base   = '0;
    end else if (sw_chg && sw == cdps_pkg::SW_DN_ON) begin
      halves_base = '0;
      fade_base   = '0;
    end else begin
      halves_base = halves_r;
      fade_base   = fade_r;
    end
  end

  // tap A steps half a sample, tap B sits half the span away
  always_comb begin
    if (pitch_up_nxt) begin
      halves_nxt = (halves_base == '0) ? SPAN2_H : halves_base - 1'b1;
    end else begin
      halves_nxt = (halves_base >= SPAN2_H) ? '0 : halves_base + 1'b1;
    end
    halves_b = (halves_nxt >= SPAN_H) ? halves_nxt - SPAN_H : halves_nxt + SPAN_H;
  end

  // triangular crossfade gain
  always_comb begin
    rising_nxt = rising_r;
    if (rising_r) begin
      if (fade_base >= SPAN_G) begin
        rising_nxt = 1'b0;
        fade_nxt   = fade_base - 1'b1;
      end else begin
        fade_nxt = fade_base + 1'b1;
      end
    end else begin
      if (fade_base == '0) begin
        rising_nxt = 1'b1;
        fade_nxt   = fade_base + 1'b1;
      end else begin
        fade_nxt = fade_base - 1'b1;
      end
    end
  end

  // write pointer and tap addresses
  assign wr_idx_nxt = (wr_idx_r == LAST_A) ? '0 : wr_idx_r + 1'b1;
  assign ra         = rd_index(halves_nxt, wr_idx_nxt);
  assign rb         = rd_index(halves_b, wr_idx_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r   <= '0;
      full_r     <= 1'b0;
      halves_r   <= '0;
      fade_r     <= '0;
      rising_r   <= 1'b1;
      pitch_up_r <= 1'b1;
      shift_en_r <= 1'b1;
      last_sw_r  <= cdps_pkg::SW_NONE;
      bias_r     <= cdps_pkg::BIAS_RESET;
    end else begin
      if (in_acc) begin
        wr_idx_r   <= wr_idx_nxt;
        full_r     <= full_r || (wr_idx_r == LAST_A);
        halves_r   <= halves_nxt;
        fade_r     <= fade_nxt;
        rising_r   <= rising_nxt;
        pitch_up_r <= pitch_up_nxt;
        shift_en_r <= shift_en_nxt;
        last_sw_r  <= {1'b0, sw};
      end
      if (cfg_valid) begin
        bias_r <= cfg_data;
      end
    end
  end

  // delay store
  cdps_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (in_acc),
    .waddr   (wr_idx_r),
    .wdata   (in_data.left_sample),
    .re      (in_acc),
    .raddr_a (ra),
    .raddr_b (rb),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // stage enables, each stage moves when empty or when the next one moves
  assign out_en   = !out_v_r || out_ready;
  assign pf_en    = !pf_v_r || out_en;
  assign dv2_en   = !dv2_v_r || pf_en;
  assign dv1_en   = !dv1_v_r || dv2_en;
  assign dv0_en   = !dv0_v_r || dv1_en;
  assign p3_en    = !p3_v_r || dv0_en;
  assign p2_en    = !p2_v_r || p3_en;
  assign p1_en    = !p1_v_r || p2_en;
  assign in_ready = p1_en;

  // stage 1: request captured while the taps are read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (p1_en) begin
      p1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p1_r.g     <= fade_nxt;
      p1_r.left  <= in_data.left_sample;
      p1_r.right <= in_data.right_sample;
      p1_r.shift <= shift_en_nxt;
      p1_r.fwd_a <= (ra == wr_idx_r);
      p1_r.fwd_b <= (rb == wr_idx_r);
      p1_r.vld_a <= full_r || (ra < wr_idx_r);
      p1_r.vld_b <= full_r || (rb < wr_idx_r);
    end
  end

  // stage 2: tap values with forwarding of the sample written alongside
  always_comb begin
    if (p1_r.fwd_a) begin
      xa = p1_r.left;
    end else if (p1_r.vld_a) begin
      xa = $signed(rd_a);
    end else begin
      xa = '0;
    end
    if (p1_r.fwd_b) begin
      xb = p1_r.left;
    end else if (p1_r.vld_b) begin
      xb = $signed(rd_b);
    end else begin
      xb = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (p2_en) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p2_en && p1_v_r) begin
      p2_r.g     <= p1_r.g;
      p2_r.diff  <= {xa[15], xa} - {xb[15], xb};
      p2_r.base  <= {{2{xb[15]}}, xb} - {3'b000, bias_r, 1'b0};
      p2_r.left  <= p1_r.left;
      p2_r.right <= p1_r.right;
      p2_r.shift <= p1_r.shift;
    end
  end

  // stage 3: gain times tap difference
  assign prod_full = $signed({1'b0, p2_r.g}) * p2_r.diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else if (p3_en) begin
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (p3_en && p2_v_r) begin
      p3_r.prod  <= prod_full[EW-1:0];
      p3_r.base  <= p2_r.base;
      p3_r.left  <= p2_r.left;
      p3_r.right <= p2_r.right;
      p3_r.shift <= p2_r.shift;
    end
  end

  // divider entry: magnitude and sign of the product
  assign mag = p3_r.prod[EW-1] ? (~p3_r.prod + 1'b1) : p3_r.prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv0_v_r <= 1'b0;
    end else if (dv0_en) begin
      dv0_v_r <= p3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (dv0_en && p3_v_r) begin
      dv0_mag_r        <= mag[MW-1:0];
      dv0_side_r.neg   <= p3_r.prod[EW-1];
      dv0_side_r.base  <= p3_r.base;
      dv0_side_r.left  <= p3_r.left;
      dv0_side_r.right <= p3_r.right;
      dv0_side_r.shift <= p3_r.shift;
    end
  end

  // quotient by the span through the reciprocal
  assign dv_prod = PW'(dv0_mag_r) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv1_v_r <= 1'b0;
    end else if (dv1_en) begin
      dv1_v_r <= dv0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (dv1_en && dv0_v_r) begin
      dv1_q_r    <= dv_prod[KSH +: QW];
      dv1_mag_r  <= dv0_mag_r;
      dv1_side_r <= dv0_side_r;
    end
  end

  // remainder check: quotient times the span against the magnitude
  assign dv_back = MW'(dv1_q_r) * SPAN_M;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv2_v_r <= 1'b0;
    end else if (dv2_en) begin
      dv2_v_r <= dv1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (dv2_en && dv1_v_r) begin
      dv2_q_r    <= dv1_q_r;
      dv2_nz_r   <= (dv1_mag_r != dv_back);
      dv2_side_r <= dv1_side_r;
    end
  end

  // final sum: tap B less twice the bias plus the signed quotient
  assign q_ext    = {3'b000, dv2_q_r};
  assign q_signed = dv2_side_r.neg ? (~q_ext + 1'b1) : q_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pf_v_r <= 1'b0;
    end else if (pf_en) begin
      pf_v_r <= dv2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pf_en && dv2_v_r) begin
      pf_r.sum      <= {dv2_side_r.base[17], dv2_side_r.base} + q_signed;
      pf_r.frac_pos <= !dv2_side_r.neg && dv2_nz_r;
      pf_r.frac_neg <= dv2_side_r.neg && dv2_nz_r;
      pf_r.left     <= dv2_side_r.left;
      pf_r.right    <= dv2_side_r.right;
      pf_r.shift    <= dv2_side_r.shift;
    end
  end

  // truncation toward zero with the fractional part, then saturation
  always_comb begin
    if (pf_r.frac_pos && pf_r.sum[18]) begin
      adj = pf_r.sum + 19'sd1;
    end else if (pf_r.frac_neg && !pf_r.sum[18] && pf_r.sum != '0) begin
      adj = pf_r.sum - 19'sd1;
    end else begin
      adj = pf_r.sum;
    end
    if (adj > 19'sd32767) begin
      sat = 16'sh7fff;
    end else if (adj < -19'sd32768) begin
      sat = -16'sh8000;
    end else begin
      sat = adj[15:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_en) begin
      out_v_r <= pf_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && pf_v_r) begin
      out_r.left_out  <= pf_r.shift ? sat : pf_r.left;
      out_r.right_out <= pf_r.right;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

@@ hdl/cdps_checker.sv @@
module cdps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input cdps_pkg::out_item_t out_data
);

  localparam int DEPTH = cdps_pkg::PIPE_DEPTH;
  localparam int CW    = $clog2(DEPTH + 1) + 1;

  logic [CW-1:0] pending_r;
  logic          in_acc;
  logic          out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // requests taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_r + CW'(in_acc) - CW'(out_acc);
    end
  end

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an empty output register never blocks the input
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // no result without a request behind it
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pending_r != '0)
    else $error("result delivered without a pending request");

  // the pipeline never holds more requests than it has stages
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= CW'(DEPTH))
    else $error("more requests pending than pipeline stages");

endmodule

bind crossfade_delay_pitch_shifter cdps_checker u_cdps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
